@@ hdl/wrs_pkg.sv @@
package wrs_pkg;

    localparam int ID_W   = 16;
    localparam int WIN_W  = 16;
    localparam int RND_W  = 31;
    localparam int POS_W  = 6;
    localparam int ST_W   = 2;
    localparam int STEP_W = $clog2(RND_W + 1);

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

@@ hdl/wrs_cell.sv @@
module wrs_cell import wrs_pkg::*; #(
    parameter int CW_W = 22
) (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [ID_W-1:0]   i_id,
    input  logic [CW_W-1:0]   i_cw,
    output logic [ID_W-1:0]   o_id,
    output logic [CW_W-1:0]   o_cw
);

    logic [ID_W-1:0] r_id;
    logic [CW_W-1:0] r_cw;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_id <= i_id;
            r_cw <= i_cw;
        end
    end

    assign o_id = r_id;
    assign o_cw = r_cw;

endmodule

@@ hdl/wrs_mod.sv @@
module wrs_mod import wrs_pkg::*; #(
    parameter int DEN_W = 22
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [RND_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [DEN_W-1:0]  o_rem
);

    logic              r_run;
    logic [STEP_W-1:0] r_step;
    logic [RND_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // restoring remainder, one dividend bit per cycle
    assign trial = {r_rem, r_num[RND_W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
        end else if (i_go) begin
            r_run  <= 1'b1;
            r_step <= STEP_W'(RND_W);
        end else if (r_run) begin
            if (r_step != '0) begin
                r_step <= r_step - 1'b1;
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run && r_step != '0) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_num <= {r_num[RND_W-2:0], 1'b0};
        end
    end

    assign o_done = r_run && (r_step == '0);
    assign o_rem  = r_rem;

endmodule

@@ hdl/weighted_random_select_unit.sv @@
// Roulette wheel selection. Each accepted transaction (start high while busy
// is low) adds one element to the list if there is room; ids and cumulative
// weights travel down a chain of MAX_ELEMENTS cells. The transaction with
// i_is_last closes the list and draws: a bit-serial remainder unit computes
// random mod total (or mod count when all weights are zero), then the chain
// shifts its contents past the tail cell one entry per cycle until the hit.
// busy stays high for the whole draw. A draw after overflow reports at once.
// The result is shown for exactly one cycle with o_valid; there is no way to
// stall it, so it must be captured when o_valid is high.
module weighted_random_select_unit import wrs_pkg::*; #(
    parameter int MAX_ELEMENTS = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ID_W-1:0]   i_element_id,
    input  logic [WIN_W-1:0]  i_weight,
    input  logic              i_is_last,
    input  logic [RND_W-1:0]  i_random_value,
    output logic              o_valid,
    output logic [ID_W-1:0]   o_chosen_element,
    output logic [POS_W-1:0]  o_chosen_position,
    output logic [ST_W-1:0]   o_status
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int TOT_W = WEIGHT_BITS + IDX_W;
    localparam logic [WIN_W-1:0] WMASK = (WEIGHT_BITS >= WIN_W) ? {WIN_W{1'b1}} :
                                         WIN_W'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W:0]   MAX_EXT = (CNT_W + 1)'(MAX_ELEMENTS);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [TOT_W-1:0] r_total, n_total;
    logic             r_ovf, n_ovf;
    logic             r_zero, n_zero;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_valid, n_valid;
    logic [ID_W-1:0]  r_elem, n_elem;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [ST_W-1:0]  r_status, n_status;

    logic             accept;
    logic             room;
    logic             shift;
    logic             div_go;
    logic             div_done;
    logic [TOT_W-1:0] div_den;
    logic [TOT_W-1:0] rem;
    logic [TOT_W-1:0] sum_total;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W:0]   kc;
    logic             in_list;
    logic [IDX_W-1:0] pos_cur;
    logic             hit;

    logic [ID_W-1:0]  c_id [MAX_ELEMENTS+1];
    logic [TOT_W-1:0] c_cw [MAX_ELEMENTS+1];

    assign busy      = (r_state != S_LOAD);
    assign accept    = start && !busy;
    assign room      = r_count < MAX_CNT;
    assign sum_total = r_total + TOT_W'(i_weight & WMASK);
    assign cnt_inc   = r_count + 1'b1;
    assign div_den   = (sum_total == '0) ? TOT_W'(cnt_inc) : sum_total;

    assign c_id[0] = i_element_id;
    assign c_cw[0] = sum_total;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_chain
            wrs_cell #(.CW_W(TOT_W)) u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_id    (c_id[gi]),
                .i_cw    (c_cw[gi]),
                .o_id    (c_id[gi+1]),
                .o_cw    (c_cw[gi+1])
            );
        end
    endgenerate

    wrs_mod #(.DEN_W(TOT_W)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_num   (i_random_value),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_rem   (rem)
    );

    // position 0 reaches the tail cell after MAX_ELEMENTS - count shifts
    assign kc      = (CNT_W + 1)'(r_k) + (CNT_W + 1)'(r_count);
    assign in_list = kc >= MAX_EXT;
    assign pos_cur = IDX_W'(kc - MAX_EXT);
    assign hit     = in_list && (r_zero ? (TOT_W'(pos_cur) == rem)
                                        : (c_cw[MAX_ELEMENTS] > rem));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_ovf    = r_ovf;
        n_zero   = r_zero;
        n_k      = r_k;
        n_valid  = 1'b0;
        n_elem   = r_elem;
        n_pos    = r_pos;
        n_status = r_status;
        shift    = 1'b0;
        div_go   = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (room) begin
                        shift   = 1'b1;
                        n_count = cnt_inc;
                        n_total = sum_total;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        if (r_ovf || !room) begin
                            n_valid  = 1'b1;
                            n_elem   = '0;
                            n_pos    = '0;
                            n_status = ST_OVERFLOW;
                            n_count  = '0;
                            n_total  = '0;
                            n_ovf    = 1'b0;
                        end else if (cnt_inc == '0) begin
                            n_valid  = 1'b1;
                            n_elem   = '0;
                            n_pos    = '0;
                            n_status = ST_EMPTY;
                            n_count  = '0;
                            n_total  = '0;
                            n_ovf    = 1'b0;
                        end else begin
                            div_go  = 1'b1;
                            n_zero  = (sum_total == '0);
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_k     = '0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                shift = 1'b1;
                n_k   = r_k + 1'b1;
                if (hit) begin
                    n_valid  = 1'b1;
                    n_elem   = c_id[MAX_ELEMENTS];
                    n_pos    = POS_W'(pos_cur);
                    n_status = ST_OK;
                    n_count  = '0;
                    n_total  = '0;
                    n_ovf    = 1'b0;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero   <= n_zero;
        r_k      <= n_k;
        r_elem   <= n_elem;
        r_pos    <= n_pos;
        r_status <= n_status;
    end

    assign o_valid           = r_valid;
    assign o_chosen_element  = r_elem;
    assign o_chosen_position = r_pos;
    assign o_status          = r_status;

endmodule
